@@ sv/qsed_pkg.sv @@
// Shared types, codes and character classification for the quoted string
// escape decoder. No dependencies; used by the interfaces and all modules.

package qsed_pkg;

	localparam int COUNT_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_FF     = 8'd12;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_VT     = 8'd11;
	localparam logic [7:0] CH_BS     = 8'd8;
	localparam logic [7:0] CH_BSLASH = 8'd92;
	localparam logic [7:0] CH_ESC    = 8'd27;
	localparam logic [7:0] CH_SQUOTE = 8'd39;
	localparam logic [7:0] CH_DQUOTE = 8'd34;
	localparam logic [7:0] CH_QMARK  = 8'd63;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DELIM = 2'd1,
		ST_QUOTE = 2'd2,
		ST_ESC   = 2'd3
	} status_t;

	// classified input word, written by the front end into the queue
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       is_oct;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       esc_known;
		logic [7:0] esc_val;
		logic       is_x;
		logic       is_bslash;
		logic       is_dq;
		logic       is_sq;
	} entry_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_end;
		status_t     status;
		logic [15:0] byte_count;
	} result_t;

	// single-character escapes: {known, value}
	function automatic logic [8:0] esc_map(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			"r":        r = {1'b1, CH_CR};
			"n":        r = {1'b1, CH_LF};
			"f":        r = {1'b1, CH_FF};
			"t":        r = {1'b1, CH_TAB};
			"v":        r = {1'b1, CH_VT};
			"b":        r = {1'b1, CH_BS};
			"e":        r = {1'b1, CH_ESC};
			CH_BSLASH:  r = {1'b1, CH_BSLASH};
			CH_SQUOTE:  r = {1'b1, CH_SQUOTE};
			CH_DQUOTE:  r = {1'b1, CH_DQUOTE};
			CH_QMARK:   r = {1'b1, CH_QMARK};
			default:    r = 9'd0;
		endcase
		return r;
	endfunction

	// hex digit of either case: {valid, value}
	function automatic logic [4:0] hex_map(input logic [7:0] c);
		logic [4:0] r;
		logic [7:0] d;
		r = 5'd0;
		if (c >= "0" && c <= "9") begin
			d = c - 8'd48;
			r = {1'b1, d[3:0]};
		end else if (c >= "A" && c <= "F") begin
			d = c - 8'd55;
			r = {1'b1, d[3:0]};
		end else if (c >= "a" && c <= "f") begin
			d = c - 8'd87;
			r = {1'b1, d[3:0]};
		end
		return r;
	endfunction

endpackage

@@ sv/qsed_if.sv @@
// Valid/ready stream interfaces for the character input and the result output.
// Depends on qsed_pkg for the status type.

interface qsed_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       final_char;

	modport source (output valid, output char_in, output final_char, input ready);
	modport sink (input valid, input char_in, input final_char, output ready);
endinterface

interface qsed_result_if;
	logic              valid;
	logic              ready;
	logic [7:0]        out_byte;
	logic              is_end;
	qsed_pkg::status_t status;
	logic [15:0]       byte_count;

	modport source (output valid, output out_byte, output is_end, output status,
		output byte_count, input ready);
	modport sink (input valid, input out_byte, input is_end, input status,
		input byte_count, output ready);
endinterface

@@ sv/qsed_front.sv @@
// Front end: accepts characters and classifies them (escape letter, octal,
// hex, quote, backslash) into a queue word. Depends on qsed_pkg, qsed_if.

module qsed_front (
	qsed_char_if.sink        char_stream,
	input  logic             push_ready,
	output logic             push_valid,
	output qsed_pkg::entry_t push_word
);

	logic [8:0] esc;
	logic [4:0] hx;
	logic [7:0] c;

	assign c   = char_stream.char_in;
	assign esc = qsed_pkg::esc_map(c);
	assign hx  = qsed_pkg::hex_map(c);

	always_comb begin
		push_word.ch        = c;
		push_word.fin       = char_stream.final_char;
		push_word.is_oct    = (c >= "0") && (c <= "7");
		push_word.is_hex    = hx[4];
		push_word.hex_val   = hx[3:0];
		push_word.esc_known = esc[8];
		push_word.esc_val   = esc[7:0];
		push_word.is_x      = (c == "x");
		push_word.is_bslash = (c == qsed_pkg::CH_BSLASH);
		push_word.is_dq     = (c == qsed_pkg::CH_DQUOTE);
		push_word.is_sq     = (c == qsed_pkg::CH_SQUOTE);
	end

	assign push_valid        = char_stream.valid;
	assign char_stream.ready = push_ready;

endmodule

@@ sv/qsed_queue.sv @@
// Short queue of classified words between front and back ends.
// Depends on qsed_pkg.

module qsed_queue #(
	parameter int DEPTH = qsed_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  qsed_pkg::entry_t push_word,
	output logic             head_valid,
	output qsed_pkg::entry_t head_word,
	input  logic             pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	qsed_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != FULL_CNT);
	assign head_valid = (fill_q != '0);
	assign head_word  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

@@ sv/qsed_back.sv @@
// Back end: escape state machine, byte counting and result output register
// with one overflow slot for items that yield two words. Depends on qsed_pkg,
// qsed_if.

module qsed_back #(
	parameter int COUNT_BITS = qsed_pkg::COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  qsed_pkg::entry_t head_word,
	output logic             pop,
	qsed_result_if.source    result_stream
);

	typedef enum logic [5:0] {
		PH_NONE = 6'b000001,
		PH_BSL  = 6'b000010,
		PH_OCT1 = 6'b000100,
		PH_OCT2 = 6'b001000,
		PH_HEX0 = 6'b010000,
		PH_HEX1 = 6'b100000
	} phase_t;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	logic                  at_start_q;
	logic                  quote_kind_q;
	phase_t                phase_q;
	logic [7:0]            accum_q;
	qsed_pkg::status_t     err_q;
	logic [COUNT_BITS-1:0] count_q;

	qsed_pkg::result_t out_q;
	logic              out_vld_q;
	qsed_pkg::result_t pend_q;
	logic              pend_vld_q;

	logic                  at_start_d;
	logic                  quote_kind_d;
	phase_t                phase_d;
	logic [7:0]            accum_d;
	qsed_pkg::status_t     err_d;
	logic [COUNT_BITS-1:0] count_d;

	logic                  put_a;
	logic [7:0]            byte_a;
	logic                  put_b;
	logic                  put_end;
	logic                  plain;
	logic                  is_quote;
	qsed_pkg::status_t     st;
	logic [COUNT_BITS-1:0] count_a;
	logic [COUNT_BITS-1:0] count_b;
	qsed_pkg::result_t     w_a;
	qsed_pkg::result_t     w_b;
	qsed_pkg::result_t     w_end;
	qsed_pkg::result_t     w0;
	qsed_pkg::result_t     w1;
	logic                  two;
	logic                  any;
	logic                  out_free;

	always_comb begin
		at_start_d   = at_start_q;
		quote_kind_d = quote_kind_q;
		phase_d      = phase_q;
		accum_d      = accum_q;
		err_d        = err_q;
		put_a        = 1'b0;
		byte_a       = accum_q;
		put_b        = 1'b0;
		put_end      = 1'b0;
		plain        = 1'b0;
		st           = qsed_pkg::ST_OK;
		is_quote     = quote_kind_q ? head_word.is_sq : head_word.is_dq;

		if (!head_word.fin) begin
			if (at_start_q) begin
				at_start_d = 1'b0;
				if (head_word.is_dq) begin
					quote_kind_d = 1'b0;
				end else if (head_word.is_sq) begin
					quote_kind_d = 1'b1;
				end else begin
					err_d = qsed_pkg::ST_DELIM;
				end
			end else if (err_q == qsed_pkg::ST_OK) begin
				case (phase_q)
					PH_BSL: begin
						phase_d = PH_NONE;
						if (head_word.esc_known) begin
							put_a  = 1'b1;
							byte_a = head_word.esc_val;
						end else if (head_word.is_x) begin
							accum_d = '0;
							phase_d = PH_HEX0;
						end else if (head_word.is_oct) begin
							accum_d = {5'd0, head_word.ch[2:0]};
							phase_d = PH_OCT1;
						end else begin
							err_d = qsed_pkg::ST_ESC;
						end
					end
					PH_OCT1, PH_OCT2: begin
						phase_d = PH_NONE;
						if (head_word.is_oct) begin
							accum_d = {accum_q[4:0], head_word.ch[2:0]};
							if (phase_q == PH_OCT2) begin
								put_a  = 1'b1;
								byte_a = accum_d;
							end else begin
								phase_d = PH_OCT2;
							end
						end else begin
							put_a = 1'b1;
							plain = 1'b1;
						end
					end
					PH_HEX0, PH_HEX1: begin
						phase_d = PH_NONE;
						if (head_word.is_hex) begin
							accum_d = {accum_q[3:0], head_word.hex_val};
							if (phase_q == PH_HEX1) begin
								put_a  = 1'b1;
								byte_a = accum_d;
							end else begin
								phase_d = PH_HEX1;
							end
						end else begin
							put_a = 1'b1;
							plain = 1'b1;
						end
					end
					default: begin
						phase_d = PH_NONE;
						plain   = 1'b1;
					end
				endcase
				if (plain) begin
					if (head_word.is_bslash) begin
						phase_d = PH_BSL;
					end else if (is_quote) begin
						err_d = qsed_pkg::ST_QUOTE;
					end else begin
						put_b = 1'b1;
					end
				end
			end
		end else begin
			put_end = 1'b1;
			if (at_start_q) begin
				st = qsed_pkg::ST_DELIM;
			end else begin
				// a pending numeric escape is flushed ahead of the end word
				put_a = (err_q == qsed_pkg::ST_OK) && (phase_q != PH_NONE)
					&& (phase_q != PH_BSL);
				if (err_q == qsed_pkg::ST_DELIM || !is_quote) begin
					st = qsed_pkg::ST_DELIM;
				end else if (err_q != qsed_pkg::ST_OK) begin
					st = err_q;
				end else if (phase_q == PH_BSL) begin
					st = qsed_pkg::ST_ESC;
				end else begin
					st = qsed_pkg::ST_OK;
				end
			end
			at_start_d   = 1'b1;
			quote_kind_d = 1'b0;
			phase_d      = PH_NONE;
			accum_d      = '0;
			err_d        = qsed_pkg::ST_OK;
		end
	end

	// saturating count, up to two bytes per word
	always_comb begin
		count_a = (put_a && count_q != CNT_MAX) ? count_q + CNT_ONE : count_q;
		count_b = (put_b && count_a != CNT_MAX) ? count_a + CNT_ONE : count_a;
		count_d = put_end ? '0 : count_b;
	end

	always_comb begin
		w_a            = '0;
		w_a.out_byte   = byte_a;
		w_b            = '0;
		w_b.out_byte   = head_word.ch;
		w_end          = '0;
		w_end.is_end   = 1'b1;
		w_end.status   = st;
		w_end.byte_count = (st == qsed_pkg::ST_OK) ? 16'(count_b) : 16'd0;
		w0  = put_a ? w_a : (put_b ? w_b : w_end);
		w1  = put_b ? w_b : w_end;
		any = put_a || put_b || put_end;
		two = put_a && (put_b || put_end);
	end

	assign out_free = !out_vld_q || result_stream.ready;
	assign pop      = head_valid && !pend_vld_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q   <= 1'b1;
			quote_kind_q <= 1'b0;
			phase_q      <= PH_NONE;
			accum_q      <= '0;
			err_q        <= qsed_pkg::ST_OK;
			count_q      <= '0;
			out_vld_q    <= 1'b0;
			pend_vld_q   <= 1'b0;
		end else begin
			if (pop) begin
				at_start_q   <= at_start_d;
				quote_kind_q <= quote_kind_d;
				phase_q      <= phase_d;
				accum_q      <= accum_d;
				err_q        <= err_d;
				count_q      <= count_d;
				out_vld_q    <= any || (out_vld_q && !result_stream.ready);
				pend_vld_q   <= two;
			end else if (pend_vld_q && out_free) begin
				out_vld_q  <= 1'b1;
				pend_vld_q <= 1'b0;
			end else if (result_stream.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (any) begin
				out_q <= w0;
			end
			if (two) begin
				pend_q <= w1;
			end
		end else if (pend_vld_q && out_free) begin
			out_q <= pend_q;
		end
	end

	assign result_stream.valid      = out_vld_q;
	assign result_stream.out_byte   = out_q.out_byte;
	assign result_stream.is_end     = out_q.is_end;
	assign result_stream.status     = out_q.status;
	assign result_stream.byte_count = out_q.byte_count;

endmodule

@@ sv/quoted_string_escape_decoder_unit.sv @@
// Quoted string escape decoder, top level: front end, queue and back end.
// Depends on qsed_pkg, qsed_if, qsed_front, qsed_queue, qsed_back.
//
// Usage: feed a quoted string on char_stream one character per word, with
// final_char set on the closing quote. Each decoded byte leaves on
// result_stream as a word with is_end low; the closing quote yields one end
// word with is_end high, the status and the decoded byte count (0 unless
// status is ok). The receiver drops the string's bytes if status is not ok.
// A character is written into the queue in its accept cycle; the back end
// pops it once its output register is free and no overflow word is pending,
// and its first result word is then registered in the output register.
// Throughput: one character per cycle while the receiver keeps ready high.
// A character that yields two words (an octal or hex escape ended by a
// literal, or a pending escape at the closing quote) holds the back end while
// the second word drains from its overflow slot; the queue of QUEUE_DEPTH
// words absorbs that and short receiver stalls.
// When the receiver stalls, the output register holds its word, the back
// end stops, and char_stream ready drops once the queue is full.
// Reset clears the queue, the escape state and the output valid.

module quoted_string_escape_decoder_unit #(
	parameter int COUNT_BITS  = qsed_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = qsed_pkg::QUEUE_DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	qsed_char_if.sink     char_stream,
	qsed_result_if.source result_stream
);

	logic             push_valid;
	logic             push_ready;
	qsed_pkg::entry_t push_word;
	logic             head_valid;
	qsed_pkg::entry_t head_word;
	logic             pop;

	qsed_front u_front (
		.char_stream (char_stream),
		.push_ready  (push_ready),
		.push_valid  (push_valid),
		.push_word   (push_word)
	);

	qsed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.head_valid (head_valid),
		.head_word  (head_word),
		.pop        (pop)
	);

	qsed_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_word     (head_word),
		.pop           (pop),
		.result_stream (result_stream)
	);

endmodule
